FILE: hw/rtl/gcbf_pkg.sv
// Shared types and constants for the ghost cell boundary fill core.
// Holds the field widths, the relation, face, axis and register codes, and the config bundle.
// No dependencies.
package gcbf_pkg;

	localparam int MAX_CELLS   = 1024;
	localparam int MAX_GHOST   = 4;
	localparam int CELLS_RESET = 64;

	localparam int CELLS_W   = 11;
	localparam int IDX_W     = 10;
	localparam int GCOORD_W  = 12;
	localparam int VAL_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int MODE_W    = 3;
	localparam int FACE_W    = 3;
	localparam int LAYER_W   = 3;
	localparam int COMP_W    = 3;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_DIRICHLET   = 3'd0,
		MODE_ZERO_GRAD   = 3'd1,
		MODE_NORMAL_GRAD = 3'd2,
		MODE_REFLECT     = 3'd3,
		MODE_CONVECTIVE  = 3'd4
	} mode_t;

	typedef enum logic [FACE_W-1:0] {
		FACE_XMIN = 3'd0,
		FACE_XMAX = 3'd1,
		FACE_YMIN = 3'd2,
		FACE_YMAX = 3'd3,
		FACE_ZMIN = 3'd4,
		FACE_ZMAX = 3'd5
	} face_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CELLS_X    = 3'd0,
		CFG_CELLS_Y    = 3'd1,
		CFG_CELLS_Z    = 3'd2,
		CFG_DIST_FIRST = 3'd3,
		CFG_DIST_LATER = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CELLS_W-1:0]      cells_x;
		logic [CELLS_W-1:0]      cells_y;
		logic [CELLS_W-1:0]      cells_z;
		logic signed [VAL_W-1:0] dist_first;
		logic signed [VAL_W-1:0] dist_later;
	} cfg_t;

	typedef struct packed {
		logic  error;
		axis_t axis;
	} geo_stat_t;

endpackage

FILE: hw/rtl/gcbf_ifs.sv
// Channel interfaces of the ghost cell boundary fill core: item, result and config write.
// Depends on gcbf_pkg for field widths.
interface gcbf_item_if;
	logic                                    valid;
	logic                                    ready;
	logic [gcbf_pkg::MODE_W-1:0]             mode;
	logic [gcbf_pkg::FACE_W-1:0]             face;
	logic [gcbf_pkg::LAYER_W-1:0]            layer;
	logic [gcbf_pkg::IDX_W-1:0]              inner;
	logic [gcbf_pkg::IDX_W-1:0]              outer;
	logic [gcbf_pkg::COMP_W-1:0]             component;
	logic signed [gcbf_pkg::VAL_W-1:0]       interior_value;
	logic signed [gcbf_pkg::VAL_W-1:0]       wall_value;
	logic signed [gcbf_pkg::VAL_W-1:0]       gradient;

	modport source(output valid, mode, face, layer, inner, outer, component,
		interior_value, wall_value, gradient, input ready);
	modport sink(input valid, mode, face, layer, inner, outer, component,
		interior_value, wall_value, gradient, output ready);
endinterface

interface gcbf_result_if;
	logic                                    valid;
	logic                                    ready;
	logic [gcbf_pkg::IDX_W-1:0]              source_x;
	logic [gcbf_pkg::IDX_W-1:0]              source_y;
	logic [gcbf_pkg::IDX_W-1:0]              source_z;
	logic signed [gcbf_pkg::GCOORD_W-1:0]    ghost_x;
	logic signed [gcbf_pkg::GCOORD_W-1:0]    ghost_y;
	logic signed [gcbf_pkg::GCOORD_W-1:0]    ghost_z;
	logic signed [gcbf_pkg::VAL_W-1:0]       ghost_value;
	logic                                    error;

	modport source(output valid, source_x, source_y, source_z, ghost_x, ghost_y, ghost_z,
		ghost_value, error, input ready);
	modport sink(input valid, source_x, source_y, source_z, ghost_x, ghost_y, ghost_z,
		ghost_value, error, output ready);
endinterface

interface gcbf_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [gcbf_pkg::CFG_IDX_W-1:0]      index;
	logic [gcbf_pkg::VAL_W-1:0]          data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/gcbf_cfg_regs.sv
// Configuration register file: cell counts (clamped on write) and normal distances.
// Depends on gcbf_pkg and gcbf_cfg_if.
module gcbf_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	gcbf_cfg_if.sink        cfg,
	output gcbf_pkg::cfg_t  regs
);

	logic [gcbf_pkg::CELLS_W-1:0]      cells_x_q, cells_y_q, cells_z_q;
	logic signed [gcbf_pkg::VAL_W-1:0] dist_first_q, dist_later_q;
	logic [gcbf_pkg::CELLS_W-1:0]      cells_wr;

	assign cfg.ready = 1'b1;

	always_comb begin
		if (cfg.data[gcbf_pkg::CELLS_W-1:0] > gcbf_pkg::CELLS_W'(gcbf_pkg::MAX_CELLS)) begin
			cells_wr = gcbf_pkg::CELLS_W'(gcbf_pkg::MAX_CELLS);
		end else begin
			cells_wr = cfg.data[gcbf_pkg::CELLS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q    <= gcbf_pkg::CELLS_W'(gcbf_pkg::CELLS_RESET);
			cells_y_q    <= gcbf_pkg::CELLS_W'(gcbf_pkg::CELLS_RESET);
			cells_z_q    <= gcbf_pkg::CELLS_W'(gcbf_pkg::CELLS_RESET);
			dist_first_q <= '0;
			dist_later_q <= '0;
		end else if (cfg.valid) begin
			case (gcbf_pkg::cfg_idx_t'(cfg.index))
				gcbf_pkg::CFG_CELLS_X:    cells_x_q    <= cells_wr;
				gcbf_pkg::CFG_CELLS_Y:    cells_y_q    <= cells_wr;
				gcbf_pkg::CFG_CELLS_Z:    cells_z_q    <= cells_wr;
				gcbf_pkg::CFG_DIST_FIRST: dist_first_q <= cfg.data;
				gcbf_pkg::CFG_DIST_LATER: dist_later_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign regs.cells_x    = cells_x_q;
	assign regs.cells_y    = cells_y_q;
	assign regs.cells_z    = cells_z_q;
	assign regs.dist_first = dist_first_q;
	assign regs.dist_later = dist_later_q;

endmodule

FILE: hw/rtl/gcbf_coord.sv
// Coordinate unit: request check, interior source cell and ghost destination cell.
// Depends on gcbf_pkg.
module gcbf_coord (
	input  logic [gcbf_pkg::MODE_W-1:0]          mode,
	input  logic [gcbf_pkg::FACE_W-1:0]          face,
	input  logic [gcbf_pkg::LAYER_W-1:0]         layer,
	input  logic [gcbf_pkg::IDX_W-1:0]           inner,
	input  logic [gcbf_pkg::IDX_W-1:0]           outer,
	input  gcbf_pkg::cfg_t                       regs,
	output logic [gcbf_pkg::IDX_W-1:0]           source_x,
	output logic [gcbf_pkg::IDX_W-1:0]           source_y,
	output logic [gcbf_pkg::IDX_W-1:0]           source_z,
	output logic signed [gcbf_pkg::GCOORD_W-1:0] ghost_x,
	output logic signed [gcbf_pkg::GCOORD_W-1:0] ghost_y,
	output logic signed [gcbf_pkg::GCOORD_W-1:0] ghost_z,
	output gcbf_pkg::geo_stat_t                  stat
);

	logic [gcbf_pkg::CELLS_W-1:0]         nn, ni, no;
	gcbf_pkg::axis_t                      axis;
	logic                                 bad;
	logic [gcbf_pkg::CELLS_W-1:0]         layer_w;
	logic [gcbf_pkg::CELLS_W-1:0]         s_norm_w;
	logic [gcbf_pkg::IDX_W-1:0]           s_norm;
	logic signed [gcbf_pkg::GCOORD_W-1:0] g_norm;
	logic [gcbf_pkg::GCOORD_W-1:0]        layer_g;

	assign layer_w = gcbf_pkg::CELLS_W'(layer);
	assign layer_g = gcbf_pkg::GCOORD_W'(layer);

	always_comb begin
		case (gcbf_pkg::face_t'(face))
			gcbf_pkg::FACE_XMIN, gcbf_pkg::FACE_XMAX: begin
				axis = gcbf_pkg::AXIS_X;
				nn   = regs.cells_x;
				ni   = regs.cells_y;
				no   = regs.cells_z;
			end
			gcbf_pkg::FACE_YMIN, gcbf_pkg::FACE_YMAX: begin
				axis = gcbf_pkg::AXIS_Y;
				nn   = regs.cells_y;
				ni   = regs.cells_x;
				no   = regs.cells_z;
			end
			default: begin
				axis = gcbf_pkg::AXIS_Z;
				nn   = regs.cells_z;
				ni   = regs.cells_x;
				no   = regs.cells_y;
			end
		endcase
	end

	assign bad = (mode > gcbf_pkg::MODE_CONVECTIVE) || (face > gcbf_pkg::FACE_ZMAX) ||
		(layer == '0) || (int'(layer) > gcbf_pkg::MAX_GHOST) || (layer_w > nn) ||
		(gcbf_pkg::CELLS_W'(inner) >= ni) || (gcbf_pkg::CELLS_W'(outer) >= no);

	// face[0] marks the high side of an axis
	assign s_norm_w = face[0] ? (nn - layer_w) : (layer_w - gcbf_pkg::CELLS_W'(1));
	assign s_norm   = s_norm_w[gcbf_pkg::IDX_W-1:0];
	assign g_norm   = face[0] ? (gcbf_pkg::GCOORD_W'(nn) - gcbf_pkg::GCOORD_W'(1) + layer_g)
		: (gcbf_pkg::GCOORD_W'(0) - layer_g);

	always_comb begin
		source_x = inner;
		source_y = outer;
		source_z = s_norm;
		ghost_x  = gcbf_pkg::GCOORD_W'(inner);
		ghost_y  = gcbf_pkg::GCOORD_W'(outer);
		ghost_z  = g_norm;
		case (axis)
			gcbf_pkg::AXIS_X: begin
				source_x = s_norm;
				source_y = inner;
				source_z = outer;
				ghost_x  = g_norm;
				ghost_y  = gcbf_pkg::GCOORD_W'(inner);
				ghost_z  = gcbf_pkg::GCOORD_W'(outer);
			end
			gcbf_pkg::AXIS_Y: begin
				source_x = inner;
				source_y = s_norm;
				source_z = outer;
				ghost_x  = gcbf_pkg::GCOORD_W'(inner);
				ghost_y  = g_norm;
				ghost_z  = gcbf_pkg::GCOORD_W'(outer);
			end
			default: ;
		endcase
		if (bad) begin
			source_x = '0;
			source_y = '0;
			source_z = '0;
			ghost_x  = '0;
			ghost_y  = '0;
			ghost_z  = '0;
		end
	end

	assign stat.error = bad;
	assign stat.axis  = axis;

endmodule

FILE: hw/rtl/gcbf_value.sv
// Value unit: applies the boundary relation in Q16.16 with truncated product and saturation.
// Depends on gcbf_pkg.
module gcbf_value (
	input  logic [gcbf_pkg::MODE_W-1:0]       mode,
	input  logic [gcbf_pkg::COMP_W-1:0]       component,
	input  logic [gcbf_pkg::LAYER_W-1:0]      layer,
	input  gcbf_pkg::axis_t                   axis,
	input  logic signed [gcbf_pkg::VAL_W-1:0] interior_value,
	input  logic signed [gcbf_pkg::VAL_W-1:0] wall_value,
	input  logic signed [gcbf_pkg::VAL_W-1:0] gradient,
	input  gcbf_pkg::cfg_t                    regs,
	output logic signed [gcbf_pkg::VAL_W-1:0] value
);

	localparam int VW   = gcbf_pkg::VAL_W;
	localparam int PW   = 2 * VW;
	localparam int QW   = PW - gcbf_pkg::FRAC_W;
	localparam int SW   = QW + 1;
	localparam int DW   = VW + 2;

	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	logic signed [VW-1:0] norm_dist;
	logic signed [PW-1:0] prod;
	logic signed [QW-1:0] quo;
	logic signed [SW-1:0] sum;
	logic signed [DW-1:0] dbl;
	logic signed [VW-1:0] dbl_sat, sum_sat, neg;

	assign norm_dist = (layer == gcbf_pkg::LAYER_W'(1)) ? regs.dist_first : regs.dist_later;
	assign prod = PW'(gradient) * PW'(norm_dist);
	// round the quotient toward zero
	assign quo  = prod[PW-1:gcbf_pkg::FRAC_W]
		+ QW'(prod[PW-1] & (|prod[gcbf_pkg::FRAC_W-1:0]));
	assign sum  = SW'(interior_value) + SW'(quo);
	assign dbl  = {wall_value[VW-1], wall_value, 1'b0} - DW'(interior_value);

	always_comb begin
		if (dbl[DW-1:VW-1] != {(DW-VW+1){dbl[DW-1]}}) begin
			dbl_sat = dbl[DW-1] ? VMIN : VMAX;
		end else begin
			dbl_sat = dbl[VW-1:0];
		end
		if (sum[SW-1:VW-1] != {(SW-VW+1){sum[SW-1]}}) begin
			sum_sat = sum[SW-1] ? VMIN : VMAX;
		end else begin
			sum_sat = sum[VW-1:0];
		end
		neg = (interior_value == VMIN) ? VMAX : -interior_value;
	end

	always_comb begin
		case (gcbf_pkg::mode_t'(mode))
			gcbf_pkg::MODE_DIRICHLET, gcbf_pkg::MODE_CONVECTIVE: value = dbl_sat;
			gcbf_pkg::MODE_ZERO_GRAD:   value = interior_value;
			gcbf_pkg::MODE_NORMAL_GRAD: value = sum_sat;
			gcbf_pkg::MODE_REFLECT: begin
				value = (component == gcbf_pkg::COMP_W'(axis)) ? neg : interior_value;
			end
			default: value = interior_value;
		endcase
	end

endmodule

FILE: hw/rtl/ghost_cell_boundary_fill_core.sv
// Top level of the ghost cell boundary fill core: input register, coordinate and value
// units, result register. Depends on gcbf_pkg, gcbf_ifs, gcbf_cfg_regs, gcbf_coord, gcbf_value.
//
// Usage:
//   item   - valid/ready channel with one ghost cell request per transaction
//            (mode, face, layer, inner, outer, component, interior, face and gradient values).
//   result - valid/ready channel with one transaction per request: source cell, ghost cell,
//            ghost value and error flag. A rejected request returns zeros and error set.
//   cfg    - write channel (index, data) for cell counts and normal distances; always ready.
//            Write only while no request is in flight.
// An accepted item loads the input register, then the result register that drives result
// valid once that register is empty or being taken. Throughput is one transaction per cycle
// unless result ready is held low; the single 32x32 product feeding the gradient sum sets the
// cycle time. While the result side stalls, the held result stays put and one further request
// can sit in the input register; item ready drops only when both are full.
// Reset clears both valid flags and loads cell counts of 64 and distances of zero.
module ghost_cell_boundary_fill_core (
	input  logic          clk,
	input  logic          arst_n,
	gcbf_item_if.sink     item,
	gcbf_result_if.source result,
	gcbf_cfg_if.sink      cfg
);

	gcbf_pkg::cfg_t      regs;
	gcbf_pkg::geo_stat_t stat;

	logic                                    v_s1;
	logic [gcbf_pkg::MODE_W-1:0]             mode_s1;
	logic [gcbf_pkg::FACE_W-1:0]             face_s1;
	logic [gcbf_pkg::LAYER_W-1:0]            layer_s1;
	logic [gcbf_pkg::IDX_W-1:0]              inner_s1;
	logic [gcbf_pkg::IDX_W-1:0]              outer_s1;
	logic [gcbf_pkg::COMP_W-1:0]             comp_s1;
	logic signed [gcbf_pkg::VAL_W-1:0]       interior_s1;
	logic signed [gcbf_pkg::VAL_W-1:0]       facev_s1;
	logic signed [gcbf_pkg::VAL_W-1:0]       grad_s1;

	logic                                    v_s2;
	logic [gcbf_pkg::IDX_W-1:0]              source_x_s2, source_y_s2, source_z_s2;
	logic signed [gcbf_pkg::GCOORD_W-1:0]    ghost_x_s2, ghost_y_s2, ghost_z_s2;
	logic signed [gcbf_pkg::VAL_W-1:0]       value_s2;
	logic                                    error_s2;

	logic [gcbf_pkg::IDX_W-1:0]              src_x, src_y, src_z;
	logic signed [gcbf_pkg::GCOORD_W-1:0]    gh_x, gh_y, gh_z;
	logic signed [gcbf_pkg::VAL_W-1:0]       value;

	logic adv_s1;
	logic take;

	assign adv_s1     = v_s1 && (!v_s2 || result.ready);
	assign item.ready = !v_s1 || adv_s1;
	assign take       = item.valid && item.ready;

	gcbf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	gcbf_coord u_coord (
		.mode     (mode_s1),
		.face     (face_s1),
		.layer    (layer_s1),
		.inner    (inner_s1),
		.outer    (outer_s1),
		.regs     (regs),
		.source_x (src_x),
		.source_y (src_y),
		.source_z (src_z),
		.ghost_x  (gh_x),
		.ghost_y  (gh_y),
		.ghost_z  (gh_z),
		.stat     (stat)
	);

	gcbf_value u_value (
		.mode           (mode_s1),
		.component      (comp_s1),
		.layer          (layer_s1),
		.axis           (stat.axis),
		.interior_value (interior_s1),
		.wall_value     (facev_s1),
		.gradient       (grad_s1),
		.regs           (regs),
		.value          (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1     <= item.mode;
			face_s1     <= item.face;
			layer_s1    <= item.layer;
			inner_s1    <= item.inner;
			outer_s1    <= item.outer;
			comp_s1     <= item.component;
			interior_s1 <= item.interior_value;
			facev_s1    <= item.wall_value;
			grad_s1     <= item.gradient;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			source_x_s2 <= src_x;
			source_y_s2 <= src_y;
			source_z_s2 <= src_z;
			ghost_x_s2  <= gh_x;
			ghost_y_s2  <= gh_y;
			ghost_z_s2  <= gh_z;
			value_s2    <= stat.error ? '0 : value;
			error_s2    <= stat.error;
		end
	end

	assign result.valid       = v_s2;
	assign result.source_x    = source_x_s2;
	assign result.source_y    = source_y_s2;
	assign result.source_z    = source_z_s2;
	assign result.ghost_x     = ghost_x_s2;
	assign result.ghost_y     = ghost_y_s2;
	assign result.ghost_z     = ghost_z_s2;
	assign result.ghost_value = value_s2;
	assign result.error       = error_s2;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.error) |->
		(result.ghost_value == '0 && result.source_x == '0 && result.ghost_x == '0))
		else $error("rejected request carries nonzero result fields");

	a_rise_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1))
		else $error("result appeared without a request in the input register");

	a_ghost_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.error) |->
		(result.ghost_x >= -12'sd4 && result.ghost_y >= -12'sd4 && result.ghost_z >= -12'sd4))
		else $error("ghost coordinate below the outermost layer");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !result.ready) |-> !item.ready)
		else $error("request taken while both stages are held");

endmodule
